>>> design/hci_crw_pkg.sv
`default_nettype none
package hci_crw_pkg;

	// Field widths
	localparam int unsigned ModeW = 2;
	localparam int unsigned ByteW = 8;
	localparam int unsigned OpcodeW = 16;
	localparam int unsigned TicksW = 16;
	localparam int unsigned OutcomeW = 2;
	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned HeadDepth = 4;

	// Request modes
	localparam logic [ModeW-1:0] MODE_BYTE = 2'd0;
	localparam logic [ModeW-1:0] MODE_TICK = 2'd1;
	localparam logic [ModeW-1:0] MODE_ARM = 2'd2;

	// Result outcomes
	localparam logic [OutcomeW-1:0] OUT_COMPLETE = 2'd0;
	localparam logic [OutcomeW-1:0] OUT_STATUS_ERR = 2'd1;
	localparam logic [OutcomeW-1:0] OUT_TIMEOUT = 2'd2;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_EXPECTED_OPCODE = 1'd0;
	localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_TICKS = 1'd1;

	// Packet codes
	localparam logic [ByteW-1:0] H4_TYPE_EVENT = 8'h04;
	localparam logic [ByteW-1:0] EVT_CMD_COMPLETE = 8'h0E;
	localparam logic [ByteW-1:0] EVT_CMD_STATUS = 8'h0F;

	localparam logic [TicksW-1:0] TIMEOUT_RESET = 16'd12000;

	// Result handed from the parser to the output register
	typedef struct packed {
		logic                valid;
		logic [OutcomeW-1:0] outcome;
		logic [ByteW-1:0]    status_code;
	} result_t;

endpackage
`default_nettype wire

>>> design/hci_crw_if.sv
`default_nettype none
interface hci_crw_req_if;
	import hci_crw_pkg::*;

	logic             valid;
	logic             ready;
	logic [ModeW-1:0] mode;
	logic [ByteW-1:0] rx_byte;

	modport source (output valid, output mode, output rx_byte, input ready);
	modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface hci_crw_rsp_if;
	import hci_crw_pkg::*;

	logic                valid;
	logic                ready;
	logic [OutcomeW-1:0] outcome;
	logic [ByteW-1:0]    status_code;

	modport source (output valid, output outcome, output status_code, input ready);
	modport sink (input valid, input outcome, input status_code, output ready);
endinterface
`default_nettype wire

>>> design/hci_crw_parser.sv
`default_nettype none
module hci_crw_parser (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           req_valid,
	output      logic                           req_ready,
	input  wire logic [hci_crw_pkg::ModeW-1:0]  req_mode,
	input  wire logic [hci_crw_pkg::ByteW-1:0]  req_byte,
	input  wire logic [hci_crw_pkg::OpcodeW-1:0] expected_opcode,
	input  wire logic [hci_crw_pkg::TicksW-1:0] timeout_ticks,
	input  wire logic                           take,
	output      hci_crw_pkg::result_t           result
);
	import hci_crw_pkg::*;

	typedef enum logic [1:0] {
		PH_TYPE,
		PH_CODE,
		PH_LEN,
		PH_PAYLOAD
	} phase_t;

	// Input stage
	logic             valid_s1;
	logic [ModeW-1:0] mode_s1;
	logic [ByteW-1:0] byte_s1;

	// Wait and parser state
	phase_t            phase_q, phase_n;
	logic              armed_q, armed_n;
	logic [ByteW-1:0]  code_q, code_n;
	logic [ByteW-1:0]  len_q, len_n;
	logic [ByteW-1:0]  idx_q, idx_n;
	logic [ByteW-1:0]  head_q [HeadDepth];
	logic [ByteW-1:0]  head_n [HeadDepth];
	logic [TicksW-1:0] ticks_q, ticks_n;
	logic              fire;

	assign fire = valid_s1 && take;
	assign req_ready = !valid_s1 || take;

	// Hold the request until the output side can take its result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			mode_s1 <= req_mode;
			byte_s1 <= req_byte;
		end
	end

	// Work out the next state and any result for the staged request
	always_comb begin
		phase_n = phase_q;
		armed_n = armed_q;
		code_n = code_q;
		len_n = len_q;
		idx_n = idx_q;
		head_n = head_q;
		ticks_n = ticks_q;
		result = '0;
		if (fire) begin
			unique case (mode_s1)
				MODE_ARM: begin
					armed_n = 1'b1;
					ticks_n = '0;
					phase_n = PH_TYPE;
					code_n = '0;
					len_n = '0;
					idx_n = '0;
					for (int i = 0; i < HeadDepth; i++) head_n[i] = '0;
				end
				MODE_BYTE: begin
					if (armed_q) begin
						unique case (phase_q)
							PH_TYPE: begin
								if (byte_s1 == H4_TYPE_EVENT) begin
									phase_n = PH_CODE;
									code_n = '0;
									len_n = '0;
									idx_n = '0;
									for (int i = 0; i < HeadDepth; i++) head_n[i] = '0;
								end
							end
							PH_CODE: begin
								code_n = byte_s1;
								phase_n = PH_LEN;
							end
							PH_LEN: begin
								// A zero length ends the packet, which then matches nothing
								len_n = byte_s1;
								idx_n = '0;
								phase_n = (byte_s1 == '0) ? PH_TYPE : PH_PAYLOAD;
							end
							PH_PAYLOAD: begin
								if (idx_q < ByteW'(HeadDepth))
									head_n[idx_q[1:0]] = byte_s1;
								idx_n = idx_q + 1'b1;
								if (idx_n >= len_q) begin
									phase_n = PH_TYPE;
									if (code_q == EVT_CMD_COMPLETE && len_q >= 8'd3 &&
										{head_n[2], head_n[1]} == expected_opcode) begin
										result.valid = 1'b1;
										result.outcome = OUT_COMPLETE;
										armed_n = 1'b0;
									end else if (code_q == EVT_CMD_STATUS && len_q >= 8'd4 &&
										{head_n[3], head_n[2]} == expected_opcode &&
										head_n[0] != '0) begin
										result.valid = 1'b1;
										result.outcome = OUT_STATUS_ERR;
										result.status_code = head_n[0];
										armed_n = 1'b0;
									end
								end
							end
							default: ;
						endcase
					end
				end
				MODE_TICK: begin
					if (armed_q) begin
						if (ticks_q != '1) ticks_n = ticks_q + 1'b1;
						if (ticks_n >= timeout_ticks) begin
							result.valid = 1'b1;
							result.outcome = OUT_TIMEOUT;
							armed_n = 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			armed_q <= 1'b0;
			code_q <= '0;
			len_q <= '0;
			idx_q <= '0;
			for (int i = 0; i < HeadDepth; i++) head_q[i] <= '0;
			ticks_q <= '0;
		end else begin
			phase_q <= phase_n;
			armed_q <= armed_n;
			code_q <= code_n;
			len_q <= len_n;
			idx_q <= idx_n;
			head_q <= head_n;
			ticks_q <= ticks_n;
		end
	end

endmodule
`default_nettype wire

>>> design/hci_crw_out_reg.sv
`default_nettype none
module hci_crw_out_reg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire hci_crw_pkg::result_t              result,
	output      logic                              take,
	output      logic                              rsp_valid,
	input  wire logic                              rsp_ready,
	output      logic [hci_crw_pkg::OutcomeW-1:0]  rsp_outcome,
	output      logic [hci_crw_pkg::ByteW-1:0]     rsp_status_code
);
	import hci_crw_pkg::*;

	logic                valid_q;
	logic [OutcomeW-1:0] outcome_q;
	logic [ByteW-1:0]    status_q;

	// Free when empty or being drained this cycle
	assign take = !valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && result.valid) begin
			outcome_q <= result.outcome;
			status_q <= result.status_code;
		end
	end

	assign rsp_valid = valid_q;
	assign rsp_outcome = outcome_q;
	assign rsp_status_code = status_q;

endmodule
`default_nettype wire

>>> design/hci_h4_command_response_waiter.sv
`default_nettype none
// Waits for the controller's answer to one HCI command. An arm request starts
// the wait; byte requests feed received UART bytes, parsed as H4 event packets;
// tick requests advance the timeout counter. One result comes out per wait:
// command complete, status error with its status byte, or timeout. Each request
// is registered, then handled by the parser against its state, so
// one request is accepted every clock while the result register is free or
// drained; a stall on the result side holds off the next request by one stage.
// Write expected_opcode and timeout_ticks only while no request is in flight.
module hci_h4_command_response_waiter (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	hci_crw_req_if.sink                            req,
	hci_crw_rsp_if.source                          rsp,
	input  wire logic                              cfg_we,
	input  wire logic [hci_crw_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [hci_crw_pkg::CfgDataW-1:0]  cfg_data
);
	import hci_crw_pkg::*;

	logic [OpcodeW-1:0] opcode_q;
	logic [TicksW-1:0]  timeout_q;
	result_t            result;
	logic               take;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opcode_q <= '0;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_EXPECTED_OPCODE: opcode_q <= cfg_data;
				CFG_TIMEOUT_TICKS:   timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	hci_crw_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req.valid),
		.req_ready       (req.ready),
		.req_mode        (req.mode),
		.req_byte        (req.rx_byte),
		.expected_opcode (opcode_q),
		.timeout_ticks   (timeout_q),
		.take            (take),
		.result          (result)
	);

	hci_crw_out_reg u_out_reg (
		.clk             (clk),
		.arst_n          (arst_n),
		.result          (result),
		.take            (take),
		.rsp_valid       (rsp.valid),
		.rsp_ready       (rsp.ready),
		.rsp_outcome     (rsp.outcome),
		.rsp_status_code (rsp.status_code)
	);

endmodule
`default_nettype wire
